@@ rtl/core/vpp_pkg.sv @@
// ----------------------------------------------------------------------------
// vpp_pkg
// shared types and constants of the perspective projection / viewport block
// ----------------------------------------------------------------------------
`default_nettype none

package vpp_pkg;

    // configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X  = 3'd0,
        REG_ROW_Y  = 3'd1,
        REG_ROW_W  = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_HEIGHT = 3'd4
    } cfg_reg_t;

    // coefficient lanes inside a row register
    localparam int LANE_W     = 16;
    localparam int NUM_LANES  = 4;
    localparam int NUM_ROWS   = 3;
    localparam int COORD_FRAC = 16;

    // viewport and pixel formats
    localparam int DIM_W = 13;
    localparam int PIX_W = 16;
    localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7fff;
    localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    // quotient bits kept by the divider; larger quotients only flag overflow
    localparam int QUOT_W = 17;

    // side info that rides along with each division
    typedef struct packed {
        logic zero_w;
        logic neg;
    } vpp_tag_t;

endpackage

`default_nettype wire

@@ rtl/core/vpp_div.sv @@
// ----------------------------------------------------------------------------
// vpp_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

module vpp_div #(
    parameter int NUM_W = 65,
    parameter int DEN_W = 51
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [NUM_W-1:0]            num,
    input  wire logic [DEN_W-1:0]            den,
    input  wire vpp_pkg::vpp_tag_t           tag_in,
    output logic                             out_valid,
    output logic [vpp_pkg::QUOT_W-1:0]       quot,
    output logic                             ovf,
    output vpp_pkg::vpp_tag_t                tag_out
);

    localparam int QB    = vpp_pkg::QUOT_W;
    localparam int CMP_W = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

    // stage 0 holds the overflow check, stages 1..QB one quotient bit each
    logic                      valid_reg [QB+1];
    logic [DEN_W-1:0]          rem_reg   [QB+1];
    logic [QB-1:0]             low_reg   [QB+1];
    logic [QB-1:0]             q_reg     [QB+1];
    logic [DEN_W-1:0]          den_reg   [QB+1];
    logic                      ovf_reg   [QB+1];
    vpp_pkg::vpp_tag_t         tag_reg   [QB+1];

    logic [DEN_W-1:0]          rem_next  [QB+1];
    logic [QB-1:0]             low_next  [QB+1];
    logic [QB-1:0]             q_next    [QB+1];
    logic [DEN_W:0]            trial     [QB];
    logic                      ge        [QB];

    // first partial remainder and the restoring step of each quotient stage
    always_comb begin
        rem_next[0] = DEN_W'(num[NUM_W-1:QB]);
        low_next[0] = num[QB-1:0];
        q_next[0]   = '0;
        for (int s = 0; s < QB; s++) begin
            trial[s]      = {rem_reg[s], low_reg[s][QB-1]};
            ge[s]         = trial[s] >= {1'b0, den_reg[s]};
            rem_next[s+1] = ge[s] ? DEN_W'(trial[s] - {1'b0, den_reg[s]}) : DEN_W'(trial[s]);
            low_next[s+1] = {low_reg[s][QB-2:0], 1'b0};
            q_next[s+1]   = {q_reg[s][QB-2:0], ge[s]};
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= QB; s++) valid_reg[s] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int s = 0; s < QB; s++) valid_reg[s+1] <= valid_reg[s];
        end
    end

    // data path
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= den;
            ovf_reg[0] <= CMP_W'(num) >= (CMP_W'(den) << QB);
            tag_reg[0] <= tag_in;
            for (int s = 0; s <= QB; s++) begin
                rem_reg[s] <= rem_next[s];
                low_reg[s] <= low_next[s];
                q_reg[s]   <= q_next[s];
            end
            for (int s = 0; s < QB; s++) begin
                den_reg[s+1] <= den_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign quot      = q_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign tag_out   = tag_reg[QB];

endmodule

`default_nettype wire

@@ rtl/core/vertex_perspective_to_pixel_top.sv @@
// ----------------------------------------------------------------------------
// vertex_perspective_to_pixel_top
// perspective projection of a Q16.16 vertex and mapping to viewport pixels
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one vertex per transaction (x, y, z in s_tdata).
//   m_ channel returns one pixel per vertex: pixel_x and pixel_y in m_tdata,
//   zero_w and saturated flags in m_tuser.
//   cfg_we/cfg_index/cfg_data write the three matrix rows and the viewport
//   size; write them only while no vertex is in flight.
// Pipeline: 4 transform stages, one overflow-check stage, 17 divider stages
//   and one output register lie between an s_ transaction and m_tvalid.
// Throughput: one vertex per cycle while the output is not stalled; the pipelined
//   divider (one quotient bit per stage) and the per-lane multipliers set this rate.
// Reset: all valid bits clear, rows reset to zero, viewport to 640x480.
// Stall: when m_tready is low with a result held, the whole pipeline holds;
//   s_tready stays high while the output register is empty or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_perspective_to_pixel_top #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // vertex input
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // vertex_x, vertex_y, vertex_z from bit 0 up, zero padded
    input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // pixel output
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // pixel_x, pixel_y from bit 0 up
    output logic [2*vpp_pkg::PIX_W-1:0]            m_tdata,
    // zero_w, saturated from bit 0 up
    output logic [1:0]                             m_tuser,
    // configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [vpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vpp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PROD_W    = COORD_WIDTH + COEF_WIDTH;
    localparam int ACC_SHIFT = (PROD_W > 48) ? PROD_W - 48 : 0;
    localparam int SP_W      = PROD_W - ACC_SHIFT;
    localparam int ACC_W     = SP_W + 2;
    localparam int NUM_W     = ACC_W + 15;
    localparam int DEN_W     = ACC_W + 1;
    localparam int QB        = vpp_pkg::QUOT_W;
    localparam int PIX_W     = vpp_pkg::PIX_W;
    localparam int DIM_W     = vpp_pkg::DIM_W;
    localparam int LANE_W    = vpp_pkg::LANE_W;
    localparam int NL        = vpp_pkg::NUM_LANES;
    localparam int NR        = vpp_pkg::NUM_ROWS;
    localparam int VY_W      = QB + 3;

    logic en;

    // configuration registers
    logic [vpp_pkg::CFG_DATA_W-1:0] row_reg [NR];
    logic [DIM_W-1:0]               width_reg;
    logic [DIM_W-1:0]               height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NR; r++) row_reg[r] <= '0;
            width_reg  <= vpp_pkg::WIDTH_RESET;
            height_reg <= vpp_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            case (vpp_pkg::cfg_reg_t'(cfg_index))
                vpp_pkg::REG_ROW_X:  row_reg[0] <= cfg_data;
                vpp_pkg::REG_ROW_Y:  row_reg[1] <= cfg_data;
                vpp_pkg::REG_ROW_W:  row_reg[2] <= cfg_data;
                vpp_pkg::REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                vpp_pkg::REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: lane products
    logic signed [COORD_WIDTH-1:0] coord [NL-1];
    logic signed [COEF_WIDTH-1:0]  coef  [NR][NL];
    logic signed [PROD_W-1:0]      prod  [NR][NL];
    logic signed [SP_W-1:0]        prod_reg [NR][NL];
    logic                          v1_reg;

    always_comb begin
        for (int k = 0; k < NL - 1; k++) begin
            coord[k] = signed'(s_tdata[k*COORD_WIDTH +: COORD_WIDTH]);
        end
        for (int r = 0; r < NR; r++) begin
            for (int k = 0; k < NL; k++) begin
                coef[r][k] = signed'(row_reg[r][k*LANE_W +: COEF_WIDTH]);
                if (k == NL - 1) begin
                    prod[r][k] = PROD_W'(coef[r][k]) <<< vpp_pkg::COORD_FRAC;
                end else begin
                    prod[r][k] = PROD_W'(coef[r][k]) * PROD_W'(coord[k]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < NR; r++)
                for (int k = 0; k < NL; k++)
                    prod_reg[r][k] <= SP_W'(prod[r][k] >>> ACC_SHIFT);
        end
    end

    // stage 2: row sums px, py, pw
    logic signed [ACC_W-1:0] acc_reg [NR];
    logic                    v2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < NR; r++) begin
                acc_reg[r] <= ACC_W'(prod_reg[r][0]) + ACC_W'(prod_reg[r][1])
                            + ACC_W'(prod_reg[r][2]) + ACC_W'(prod_reg[r][3]);
            end
        end
    end

    // stage 3: viewport numerators and doubled w
    logic signed [ACC_W:0]   sum_x, sum_y;
    logic signed [NUM_W-1:0] nx_reg, ny_reg;
    logic signed [DEN_W-1:0] den_reg;
    logic                    zero3_reg;
    logic                    v3_reg;

    assign sum_x = (ACC_W+1)'(acc_reg[0]) + (ACC_W+1)'(acc_reg[2]);
    assign sum_y = (ACC_W+1)'(acc_reg[1]) + (ACC_W+1)'(acc_reg[2]);

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg    <= NUM_W'(sum_x) * NUM_W'(signed'({1'b0, width_reg}));
            ny_reg    <= NUM_W'(sum_y) * NUM_W'(signed'({1'b0, height_reg}));
            den_reg   <= DEN_W'(acc_reg[2]) <<< 1;
            zero3_reg <= acc_reg[2] == '0;
        end
    end

    // stage 4: magnitudes and quotient signs
    logic [NUM_W-1:0]  mx_reg, my_reg;
    logic [DEN_W-1:0]  md_reg;
    vpp_pkg::vpp_tag_t tagx_reg, tagy_reg;
    logic              v4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg <= nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
            my_reg <= ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
            // a zero w gets a divisor of one so the divider never sees zero
            md_reg <= zero3_reg ? DEN_W'(1)
                    : (den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg));
            tagx_reg.zero_w <= zero3_reg;
            tagx_reg.neg    <= nx_reg[NUM_W-1] ^ den_reg[DEN_W-1];
            tagy_reg.zero_w <= zero3_reg;
            tagy_reg.neg    <= ny_reg[NUM_W-1] ^ den_reg[DEN_W-1];
        end
    end

    // valid bits of the transform stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // dividers
    logic              dvx_valid, dvy_valid, ovfx, ovfy;
    logic [QB-1:0]     qx, qy;
    vpp_pkg::vpp_tag_t tagx, tagy;

    vpp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v4_reg),
        .num(mx_reg), .den(md_reg), .tag_in(tagx_reg),
        .out_valid(dvx_valid), .quot(qx), .ovf(ovfx), .tag_out(tagx)
    );

    vpp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v4_reg),
        .num(my_reg), .den(md_reg), .tag_in(tagy_reg),
        .out_valid(dvy_valid), .quot(qy), .ovf(ovfy), .tag_out(tagy)
    );

    // signs, vertical flip and clamping
    logic signed [QB:0]      sx, sy;
    logic signed [VY_W-1:0]  vy;
    logic signed [PIX_W-1:0] px_next, py_next;
    logic                    zero_next, sat_next;

    always_comb begin
        sx = tagx.neg ? -signed'({1'b0, qx}) : signed'({1'b0, qx});
        sy = tagy.neg ? -signed'({1'b0, qy}) : signed'({1'b0, qy});
        vy = signed'(VY_W'(height_reg)) - VY_W'(sy);
        sat_next  = 1'b0;
        zero_next = tagx.zero_w;
        if (ovfx) begin
            sat_next = 1'b1;
            px_next  = tagx.neg ? vpp_pkg::PIX_MIN : vpp_pkg::PIX_MAX;
        end else if (sx[QB:PIX_W-1] != {(QB-PIX_W+2){sx[QB]}}) begin
            sat_next = 1'b1;
            px_next  = sx[QB] ? vpp_pkg::PIX_MIN : vpp_pkg::PIX_MAX;
        end else begin
            px_next  = PIX_W'(sx);
        end
        if (ovfy) begin
            sat_next = 1'b1;
            py_next  = tagy.neg ? vpp_pkg::PIX_MAX : vpp_pkg::PIX_MIN;
        end else if (vy[VY_W-1:PIX_W-1] != {(VY_W-PIX_W+1){vy[VY_W-1]}}) begin
            sat_next = 1'b1;
            py_next  = vy[VY_W-1] ? vpp_pkg::PIX_MIN : vpp_pkg::PIX_MAX;
        end else begin
            py_next  = PIX_W'(vy);
        end
        if (zero_next) begin
            sat_next = 1'b0;
            px_next  = '0;
            py_next  = '0;
        end
    end

    // output register
    logic                    m_valid_reg;
    logic signed [PIX_W-1:0] px_reg, py_reg;
    logic                    zero_reg, sat_reg;

    assign en = m_tready || !m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dvx_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            zero_reg <= zero_next;
            sat_reg  <= sat_next;
        end
    end

    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {py_reg, px_reg};
    assign m_tuser  = {sat_reg, zero_reg};

    // checks
    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        dvx_valid == dvy_valid)
        else $error("x and y dividers out of step");

    a_zero_w_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("zero w result carries pixels or saturation");

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (px_reg == vpp_pkg::PIX_MAX || px_reg == vpp_pkg::PIX_MIN
            || py_reg == vpp_pkg::PIX_MAX || py_reg == vpp_pkg::PIX_MIN))
        else $error("saturated flag without a clamped coordinate");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && !$past(aresetn)) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
